### design/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// Space vector PWM duty unit package
// Shared constants, widths and the item type that crosses the queue between
// the sector front end and the division back end.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int INPUT_FRAC_BITS_DEF = 14;

    localparam logic signed [31:0] SQRT3_HALF_Q30 = 32'sd929887697;

    localparam logic [15:0] DUTY_ONE  = 16'd32768;
    localparam logic [15:0] DUTY_HALF = 16'd16384;
    localparam logic [15:0] DUTY_ZERO = 16'd0;

    localparam int SIG_W     = 48;
    localparam int XY_W      = 47;
    localparam int SUM_W     = 48;
    localparam int DIV_STEPS = 16;
    localparam int NUM_W     = SUM_W + DIV_STEPS;
    localparam int Q_DEPTH   = 4;

    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    typedef struct packed {
        logic [2:0]       code;
        logic             over;
        logic [1:0]       idx_mid;
        logic [2:0][15:0] duty;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } t_q_item;

endpackage

### design/svpwm_seven_segment_duty_unit.sv
// ----------------------------------------------------------------------------
// Seven-segment space vector PWM duty unit
// Turns one normalized (alpha, beta) voltage vector into three phase duties,
// the sector code and an overmodulation flag.
// ----------------------------------------------------------------------------
// Usage: an input item (alpha, beta) is taken at a clock edge where i_valid
// is high and o_stall is low. A result item is delivered at an edge where
// o_valid is high and i_stall is low; it holds steady while stalled.
// One result comes out for every input item, in order.
// From the accepting edge to o_valid an item passes three front-end stages,
// the queue, the 16-stage divider and the output register.
// Every item takes the same path, so the latency does not depend on data.
// Unstalled, throughput is one item per cycle; the divider takes one each cycle.
// When the receiver stalls, the back end holds and the four-entry queue
// keeps taking items until it fills; only then does o_stall rise.
// Reset is synchronous and active low; it empties the pipeline and the
// queue and needs no clearing time.
// ----------------------------------------------------------------------------
module svpwm_seven_segment_duty_unit #(
    parameter int INPUT_FRAC_BITS = svpwm_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_alpha_voltage,
    input  logic signed [15:0]   i_beta_voltage,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_duty_phase_u,
    output logic [15:0]          o_duty_phase_v,
    output logic [15:0]          o_duty_phase_w,
    output logic [2:0]           o_sector_code,
    output logic                 o_overmodulated
);
    import svpwm_pkg::*;

    t_q_item front_item;
    t_q_item head_item;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;

    svpwm_front #(
        .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_alpha_voltage(i_alpha_voltage),
        .i_beta_voltage (i_beta_voltage),
        .o_push         (push),
        .i_full         (q_full),
        .o_item         (front_item)
    );

    svpwm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (head_item)
    );

    svpwm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_duty_phase_u (o_duty_phase_u),
        .o_duty_phase_v (o_duty_phase_v),
        .o_duty_phase_w (o_duty_phase_w),
        .o_sector_code  (o_sector_code),
        .o_overmodulated(o_overmodulated)
    );

endmodule

### design/svpwm_front.sv
// ----------------------------------------------------------------------------
// Space vector PWM front end
// Forms the sector signals, the sector code and the two dwell times, and
// prepares the phase duties and the divider operands of one item.
// ----------------------------------------------------------------------------
module svpwm_front #(
    parameter int INPUT_FRAC_BITS = svpwm_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_alpha_voltage,
    input  logic signed [15:0]   i_beta_voltage,
    output logic                 o_push,
    input  logic                 i_full,
    output svpwm_pkg::t_q_item   o_item
);
    import svpwm_pkg::*;

    localparam int VW = (INPUT_FRAC_BITS + 32 > SUM_W + 1) ? INPUT_FRAC_BITS + 32 : SUM_W + 1;
    localparam logic [VW-1:0] PERIOD   = VW'(1) << (INPUT_FRAC_BITS + 30);
    localparam logic [VW-1:0] HALF_LSB = VW'(1) << (INPUT_FRAC_BITS + 15);

    localparam logic [1:0] SEL_S1 = 2'd0;
    localparam logic [1:0] SEL_S2 = 2'd1;
    localparam logic [1:0] SEL_S3 = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [1:0] x_sel;
        logic       x_neg;
        logic [1:0] y_sel;
        logic       y_neg;
        logic [1:0] idx_big;
        logic [1:0] idx_mid;
        logic [1:0] idx_low;
    } t_sector;

    function automatic t_sector sector_lookup(input logic [2:0] code);
        t_sector m;
        m = '0;
        case (code)
            3'd5: m = '{1'b1, SEL_S3, 1'b0, SEL_S1, 1'b0, PH_U, PH_V, PH_W};
            3'd1: m = '{1'b1, SEL_S3, 1'b1, SEL_S2, 1'b1, PH_V, PH_U, PH_W};
            3'd3: m = '{1'b1, SEL_S1, 1'b0, SEL_S2, 1'b0, PH_V, PH_W, PH_U};
            3'd2: m = '{1'b1, SEL_S1, 1'b1, SEL_S3, 1'b1, PH_W, PH_V, PH_U};
            3'd6: m = '{1'b1, SEL_S2, 1'b0, SEL_S3, 1'b0, PH_W, PH_U, PH_V};
            3'd4: m = '{1'b1, SEL_S2, 1'b1, SEL_S1, 1'b1, PH_U, PH_W, PH_V};
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [XY_W-1:0] pick_time(
        input logic signed [SIG_W-1:0] s1,
        input logic signed [SIG_W-1:0] s2,
        input logic signed [SIG_W-1:0] s3,
        input logic [1:0]              sel,
        input logic                    neg
    );
        logic signed [SIG_W-1:0] v;
        v = s1;
        case (sel)
            SEL_S1:  v = s1;
            SEL_S2:  v = s2;
            SEL_S3:  v = s3;
            default: v = s1;
        endcase
        if (neg) begin
            v = -v;
        end
        return v[SIG_W-1] ? '0 : v[XY_W-1:0];
    endfunction

    function automatic logic [15:0] to_duty(input logic [VW-1:0] v);
        logic [VW-1:0] sh;
        sh = v >> (INPUT_FRAC_BITS + 16);
        return (sh > VW'(DUTY_ONE)) ? DUTY_ONE : sh[15:0];
    endfunction

    logic                    front_en;

    logic                    r1_v;
    logic signed [SIG_W-1:0] r1_ka;
    logic signed [15:0]      r1_b;

    logic                    r2_v;
    logic signed [SIG_W-1:0] r2_s1;
    logic signed [SIG_W-1:0] r2_s2;
    logic signed [SIG_W-1:0] r2_s3;
    logic [2:0]              r2_code;

    logic                    r3_v;
    logic [2:0]              r3_code;
    t_sector                 r3_map;
    logic [XY_W-1:0]         r3_x;
    logic [XY_W-1:0]         r3_y;
    logic [SUM_W-1:0]        r3_sum;

    logic signed [SIG_W-1:0] n_s1;
    logic signed [SIG_W-1:0] n_s2;
    logic signed [SIG_W-1:0] n_s3;
    logic signed [SIG_W-1:0] hb;
    logic [2:0]              n_code;
    t_sector                 n_map;
    logic [XY_W-1:0]         n_x;
    logic [XY_W-1:0]         n_y;

    logic [VW-1:0]           sum_ext;
    logic [VW-1:0]           v_big;
    logic [VW-1:0]           v_mid;
    logic [VW-1:0]           v_low;
    logic                    over;

    assign front_en = !r3_v || !i_full;
    assign o_stall  = !front_en;
    assign o_push   = r3_v && !i_full;

    always_comb begin
        hb     = SIG_W'(r1_b) <<< 29;
        n_s1   = SIG_W'(r1_b) <<< 30;
        n_s2   = -r1_ka - hb;
        n_s3   = r1_ka - hb;
        n_code = {!n_s3[SIG_W-1] && (n_s3 != '0),
                  !n_s2[SIG_W-1] && (n_s2 != '0),
                  !n_s1[SIG_W-1] && (n_s1 != '0)};
    end

    always_comb begin
        n_map = sector_lookup(r2_code);
        n_x   = pick_time(r2_s1, r2_s2, r2_s3, n_map.x_sel, n_map.x_neg);
        n_y   = pick_time(r2_s1, r2_s2, r2_s3, n_map.y_sel, n_map.y_neg);
    end

    always_comb begin
        sum_ext = VW'(r3_sum);
        v_big   = PERIOD + sum_ext + HALF_LSB;
        v_mid   = PERIOD - VW'(r3_x) + VW'(r3_y) + HALF_LSB;
        v_low   = PERIOD - sum_ext + HALF_LSB;
        over    = r3_map.ok && (sum_ext > PERIOD);

        o_item         = '0;
        o_item.code    = r3_code;
        o_item.over    = over;
        o_item.idx_mid = r3_map.idx_mid;
        o_item.num     = (NUM_W'(r3_y) << 15) + NUM_W'(r3_sum >> 1);
        o_item.den     = r3_sum;
        if (!r3_map.ok) begin
            o_item.duty = {DUTY_HALF, DUTY_HALF, DUTY_HALF};
        end else if (over) begin
            o_item.duty[r3_map.idx_big] = DUTY_ONE;
            o_item.duty[r3_map.idx_mid] = DUTY_ZERO;
            o_item.duty[r3_map.idx_low] = DUTY_ZERO;
        end else begin
            o_item.duty[r3_map.idx_big] = to_duty(v_big);
            o_item.duty[r3_map.idx_mid] = to_duty(v_mid);
            o_item.duty[r3_map.idx_low] = to_duty(v_low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (front_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (front_en) begin
            r1_ka   <= i_alpha_voltage * SQRT3_HALF_Q30;
            r1_b    <= i_beta_voltage;
            r2_s1   <= n_s1;
            r2_s2   <= n_s2;
            r2_s3   <= n_s3;
            r2_code <= n_code;
            r3_code <= r2_code;
            r3_map  <= n_map;
            r3_x    <= n_x;
            r3_y    <= n_y;
            r3_sum  <= SUM_W'(n_x) + SUM_W'(n_y);
        end
    end

endmodule

### design/svpwm_queue.sv
// ----------------------------------------------------------------------------
// Space vector PWM item queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module svpwm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  svpwm_pkg::t_q_item   i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output svpwm_pkg::t_q_item   o_head
);
    import svpwm_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);

    t_q_item        r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### design/svpwm_back.sv
// ----------------------------------------------------------------------------
// Space vector PWM back end
// Pipelined restoring divider, one quotient bit per stage, that scales the
// middle duty of an overmodulated item, followed by the output register.
// ----------------------------------------------------------------------------
module svpwm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  svpwm_pkg::t_q_item   i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_duty_phase_u,
    output logic [15:0]          o_duty_phase_v,
    output logic [15:0]          o_duty_phase_w,
    output logic [2:0]           o_sector_code,
    output logic                 o_overmodulated
);
    import svpwm_pkg::*;

    logic                 back_en;

    logic                 r_v    [DIV_STEPS+1];
    t_q_item              r_item [DIV_STEPS+1];
    logic [SUM_W-1:0]     r_rem  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_quo  [DIV_STEPS+1];

    logic [SUM_W:0]       n_trial [DIV_STEPS];
    logic                 n_bit   [DIV_STEPS];
    logic [SUM_W-1:0]     n_rem   [DIV_STEPS];

    t_q_item              last;
    logic [15:0]          mid_duty;
    logic [2:0][15:0]     n_duty;

    logic                 r_out_valid;
    logic [2:0][15:0]     r_duty;
    logic [2:0]           r_code;
    logic                 r_over;

    assign back_en = !r_out_valid || !i_stall;
    assign o_pop   = back_en && !i_empty;

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_trial[k] = {r_rem[k], r_low[k][DIV_STEPS-1]};
            n_bit[k]   = (n_trial[k] >= {1'b0, r_item[k].den});
            n_rem[k]   = n_bit[k] ? SUM_W'(n_trial[k] - {1'b0, r_item[k].den})
                                  : n_trial[k][SUM_W-1:0];
        end
    end

    always_comb begin
        last     = r_item[DIV_STEPS];
        mid_duty = (r_quo[DIV_STEPS] > DUTY_ONE) ? DUTY_ONE : r_quo[DIV_STEPS];
        n_duty   = last.duty;
        if (last.over) begin
            n_duty[last.idx_mid] = mid_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (back_en) begin
            r_v[0] <= !i_empty;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_valid <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_en) begin
            r_item[0] <= i_head;
            r_rem[0]  <= i_head.num[NUM_W-1:DIV_STEPS];
            r_low[0]  <= i_head.num[DIV_STEPS-1:0];
            r_quo[0]  <= '0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_item[k+1] <= r_item[k];
                r_rem[k+1]  <= n_rem[k];
                r_low[k+1]  <= {r_low[k][DIV_STEPS-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][DIV_STEPS-2:0], n_bit[k]};
            end
            if (r_v[DIV_STEPS]) begin
                r_duty <= n_duty;
                r_code <= last.code;
                r_over <= last.over;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_duty_phase_u  = r_duty[PH_U];
    assign o_duty_phase_v  = r_duty[PH_V];
    assign o_duty_phase_w  = r_duty[PH_W];
    assign o_sector_code   = r_code;
    assign o_overmodulated = r_over;

endmodule
